// ===== src/kmsl_pkg.sv =====
package kmsl_pkg;

  // Payload widths fixed by the channel formats
  localparam int unsigned DirectW = 2;
  localparam int unsigned RowSenseW = 4;
  localparam int unsigned DriveW = 4;
  localparam int unsigned CodeW = 6;
  localparam int unsigned TickW = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [TickW-1:0] DebounceReset = 16'd20;
  localparam logic [TickW-1:0] LongPressReset = 16'd3000;

  // Added to a key code when the hold reached the long-press threshold
  localparam logic [CodeW-1:0] LongFlag = 6'd32;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } cfg_reg_e;

  // Scanner phase, one-hot
  typedef enum logic [2:0] {
    PH_SCAN     = 3'b001,
    PH_DEBOUNCE = 3'b010,
    PH_HOLD     = 3'b100
  } phase_e;

  // One result beat
  typedef struct packed {
    logic [DriveW-1:0] column_drive;
    logic              key_valid;
    logic [CodeW-1:0]  key_code;
  } result_t;

endpackage

// ===== src/kmsl_in_if.sv =====
interface kmsl_in_if;
  import kmsl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DirectW-1:0]   direct_keys;
  logic [RowSenseW-1:0] row_sense;

  modport source (output valid, output direct_keys, output row_sense, input ready);
  modport sink (input valid, input direct_keys, input row_sense, output ready);
endinterface

interface kmsl_out_if;
  import kmsl_pkg::*;

  logic              valid;
  logic              ready;
  logic [DriveW-1:0] column_drive;
  logic              key_valid;
  logic [CodeW-1:0]  key_code;

  modport source (output valid, output column_drive, output key_valid, output key_code,
                  input ready);
  modport sink (input valid, input column_drive, input key_valid, input key_code,
                output ready);
endinterface

interface kmsl_cfg_if;
  import kmsl_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/keypad_matrix_scan_long_press.sv =====
// Channel   Dir  Handshake        Payload
// in_i      in   valid / ready    direct_keys[1:0], row_sense[3:0]   (one tick per beat)
// out_o     out  valid / ready    column_drive[3:0], key_valid, key_code[5:0]
// cfg_i     in   valid / ready    index (0 debounce_ticks, 1 long_press_ticks), data[15:0]
//
// Each input beat is one tick; its result is registered in the output buffer.
// One beat per cycle while the skid entry is empty: the scan state updates at acceptance.
// A two-entry output buffer (result register plus skid) lets a beat be taken while a
// result waits; input stalls only when both entries are full.
// Reset (rst_ni, async low): scanning at position 0, counters cleared, registers at
// 20 / 3000. cfg_i is always ready.
module keypad_matrix_scan_long_press #(
  parameter int unsigned COLUMNS = 4,
  parameter int unsigned ROWS    = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kmsl_in_if.sink    in_i,
  kmsl_out_if.source out_o,
  kmsl_cfg_if.sink   cfg_i
);
  import kmsl_pkg::*;

  localparam int unsigned NPos = COLUMNS + 2;
  localparam int unsigned PosW = $clog2(NPos);
  localparam int unsigned KeyW = $clog2(COLUMNS * ROWS + 3);
  localparam int unsigned RowScan = (ROWS < 4) ? ROWS : 4;

  logic [TickW-1:0] debounce_q, long_press_q;
  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d, pos_cur, pos_next;
  logic [KeyW-1:0]  held_key_q, held_key_d;
  logic [1:0]       row_q, row_d;
  logic [TickW-1:0] tick_q, tick_d, tick_inc;

  logic             found;
  logic [KeyW-1:0]  found_key;
  logic [1:0]       found_row;
  logic             hold_down;
  logic             in_acc;
  result_t          res;

  result_t          main_q, skid_q;
  logic             main_v_q, skid_v_q;
  logic             pop;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      long_press_q <= LongPressReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_DEBOUNCE:   debounce_q <= cfg_i.data;
        REG_LONG_PRESS: long_press_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Current and following scan position
  always_comb begin
    pos_cur  = (int'(pos_q) >= int'(NPos)) ? '0 : pos_q;
    pos_next = (int'(pos_cur) == int'(NPos) - 1) ? '0 : pos_cur + PosW'(1);
    tick_inc = (tick_q == '1) ? tick_q : tick_q + TickW'(1);
  end

  // Find the first pressed key at the current position
  always_comb begin
    found     = 1'b0;
    found_key = '0;
    found_row = '0;
    if (int'(pos_cur) < 2) begin
      found     = !in_i.direct_keys[pos_cur[0]];
      found_key = KeyW'(COLUMNS * ROWS + 1) + KeyW'(pos_cur);
    end else begin
      for (int r = RowScan - 1; r >= 0; r--) begin
        if (in_i.row_sense[r]) begin
          found     = 1'b1;
          found_row = 2'(r);
          found_key = KeyW'(ROWS) * (KeyW'(pos_cur) - KeyW'(2)) + KeyW'(ROWS) - KeyW'(r);
        end
      end
    end
  end

  // Level of the held key
  assign hold_down = (int'(pos_cur) < 2) ? !in_i.direct_keys[pos_cur[0]]
                                         : in_i.row_sense[row_q];

  // Next scan state and the result of this tick
  always_comb begin
    phase_d          = phase_q;
    pos_d            = pos_cur;
    held_key_d       = held_key_q;
    row_d            = row_q;
    tick_d           = tick_q;
    res.key_valid    = 1'b0;
    res.key_code     = '0;
    res.column_drive = '0;
    case (phase_q)
      PH_DEBOUNCE: begin
        tick_d = tick_inc;
        if (tick_inc >= debounce_q) begin
          phase_d = PH_HOLD;
          tick_d  = '0;
        end
      end
      PH_HOLD: begin
        if (hold_down) begin
          tick_d = tick_inc;
        end else begin
          res.key_valid = 1'b1;
          res.key_code  = CodeW'(held_key_q) + ((tick_q >= long_press_q) ? LongFlag : '0);
          phase_d       = PH_SCAN;
          tick_d        = '0;
          held_key_d    = '0;
          pos_d         = pos_next;
        end
      end
      default: begin
        if (found) begin
          held_key_d = found_key;
          row_d      = found_row;
          tick_d     = '0;
          phase_d    = (debounce_q == '0) ? PH_HOLD : PH_DEBOUNCE;
        end else begin
          phase_d = PH_SCAN;
          pos_d   = pos_next;
        end
      end
    endcase
    for (int c = 0; c < DriveW; c++) begin
      res.column_drive[c] = (c < COLUMNS) && (int'(pos_d) == c + 2);
    end
  end

  assign in_i.ready = !skid_v_q;
  assign in_acc     = in_i.valid && in_i.ready;

  // Advance the scan state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SCAN;
      pos_q      <= '0;
      held_key_q <= '0;
      row_q      <= '0;
      tick_q     <= '0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      held_key_q <= held_key_d;
      row_q      <= row_d;
      tick_q     <= tick_d;
    end
  end

  // Two-entry output buffer: result register and skid
  assign pop = main_v_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (in_acc) begin
      if (main_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end else if (pop) begin
      main_v_q <= skid_v_q;
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (main_v_q && !pop) begin
        skid_q <= res;
      end else begin
        main_q <= res;
      end
    end else if (pop && skid_v_q) begin
      main_q <= skid_q;
    end
  end

  assign out_o.valid        = main_v_q;
  assign out_o.column_drive = main_q.column_drive;
  assign out_o.key_valid    = main_q.key_valid;
  assign out_o.key_code     = main_q.key_code;

  // A waiting skid entry always sits behind a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> main_v_q)
    else $error("skid entry valid without a result entry");

  // The scan position never leaves the position range
  assert property (@(posedge clk_i) disable iff (!rst_ni) int'(pos_q) < int'(NPos))
    else $error("scan position out of range");

  // A key is held whenever debounce or hold is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (phase_q == PH_DEBOUNCE || phase_q == PH_HOLD) |-> held_key_q != '0)
    else $error("debounce or hold without a held key");

  // A release returns the scanner to scanning
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_acc && phase_q == PH_HOLD && !hold_down) |=> phase_q == PH_SCAN)
    else $error("release did not return to scanning");

endmodule
